// ===== rtl/core/bez_pkg.sv =====
// Shared constants, types and state encodings for the quadratic curve point generator.
package bez_pkg;

	// Width and reset value of the step count register.
	localparam int STEPS_W = 6;
	localparam logic [STEPS_W-1:0] STEPS_RESET = 6'd20;

	// Defaults for the top-level parameters.
	localparam int COORD_BITS_DEF = 8;
	localparam int MAX_STEPS_DEF  = 63;

	// Queue depths; both must be powers of two.
	localparam int SEG_DEPTH = 2;
	localparam int OUT_DEPTH = 16;

	// Fill status reported by a queue to its producer and consumer.
	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	// Step sequencer states.
	typedef enum logic {
		SEQ_IDLE,
		SEQ_RUN
	} seq_state_t;

endpackage

// ===== rtl/core/bez_queue.sv =====
// Small first-in first-out queue built from registers.
module bez_queue
	import bez_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = SEG_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] head_data,
	output queue_status_t    status
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	// Entry storage; the producer never pushes into a full queue.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign head_data    = mem_q[rd_ptr_q];
	assign status.full  = (count_q == CW'(DEPTH));
	assign status.empty = (count_q == '0);

endmodule

// ===== rtl/core/bez_front.sv =====
// Front end: holds the step count register, accepts segments and classifies them.
module bez_front
	import bez_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int MAX_STEPS  = MAX_STEPS_DEF,
	parameter int IN_TDW     = ((6 * COORD_BITS + 7) / 8) * 8,
	parameter int NW         = $clog2(MAX_STEPS + 1),
	parameter int SEG_W      = 6 * COORD_BITS + NW + 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [STEPS_W-1:0] cfg_data,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [IN_TDW-1:0]  s_axis_tdata,
	input  queue_status_t      seg_status,
	output logic               seg_push,
	output logic [SEG_W-1:0]   seg_data
);

	logic [STEPS_W-1:0] steps_q;
	logic [NW-1:0]      n_sat;
	logic [NW-1:0]      n_eff;
	logic               single;

	// Step count register; the user must write it only while the block is idle, which the block does not enforce.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= STEPS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			steps_q <= cfg_data;
		end
	end

	assign cfg_ready = 1'b1;

	// Saturate the step count. A zero count is run as one step that emits
	// only the first point, which equals the start point exactly.
	always_comb begin
		if (steps_q > STEPS_W'(MAX_STEPS)) begin
			n_sat = NW'(MAX_STEPS);
		end else begin
			n_sat = NW'(steps_q);
		end
		single = (steps_q == '0);
		n_eff  = single ? NW'(1) : n_sat;
	end

	// Hand accepted segments to the queue.
	assign s_axis_tready = !seg_status.full;
	assign seg_push      = s_axis_tvalid && s_axis_tready;
	assign seg_data      = {single, n_eff, s_axis_tdata[6*COORD_BITS-1:0]};

endmodule

// ===== rtl/core/bez_back.sv =====
// Back end: steps the curve parameter and evaluates both coordinates in a pipeline.
module bez_back
	import bez_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int MAX_STEPS  = MAX_STEPS_DEF,
	parameter int NW         = $clog2(MAX_STEPS + 1),
	parameter int SEG_W      = 6 * COORD_BITS + NW + 1,
	parameter int PT_W       = 2 * COORD_BITS + 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  queue_status_t    seg_status,
	input  logic [SEG_W-1:0] seg_data,
	output logic             seg_pop,
	input  logic             out_pop,
	output logic             pt_push,
	output logic [PT_W-1:0]  pt_data
);

	localparam int C   = COORD_BITS;
	localparam int DW  = $clog2(MAX_STEPS * MAX_STEPS + 1);
	localparam int S   = C + DW;
	localparam int CRW = $clog2(OUT_DEPTH + 1);
	localparam int CDW = 6 * C;

	// Reciprocal table: floor((2^S - 1) / n^2). Any numerator stays below
	// 2^S, so the scaled estimate is at most one below the true quotient.
	localparam logic [S-1:0] RECIP_NUM = {S{1'b1}};

	logic [S-1:0] recip_tbl [MAX_STEPS+1];

	assign recip_tbl[0] = '0;
	for (genvar k = 1; k <= MAX_STEPS; k++) begin : g_recip
		localparam logic [S-1:0] RECIP_K = S'(RECIP_NUM / (k * k));
		assign recip_tbl[k] = RECIP_K;
	end

	// Queue head fields.
	logic [CDW-1:0] head_coords;
	logic [NW-1:0]  head_n;
	logic           head_single;

	assign head_coords = seg_data[CDW-1:0];
	assign head_n      = seg_data[CDW +: NW];
	assign head_single = seg_data[CDW+NW];

	// Sequencer state and the segment being stepped.
	seq_state_t     state_q, state_d;
	logic [CDW-1:0] coords_q;
	logic [NW-1:0]  n_q;
	logic [NW-1:0]  end_q;
	logic [NW-1:0]  t_q;
	logic [DW-1:0]  d_q;
	logic [S-1:0]   r_q;
	logic [CRW-1:0] inflight_q;
	logic           credit_ok;
	logic           issue;

	assign credit_ok = (inflight_q < CRW'(OUT_DEPTH));

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SEQ_IDLE: begin
				if (!seg_status.empty) begin
					state_d = SEQ_RUN;
				end
			end
			SEQ_RUN: begin
				if (credit_ok && (t_q == end_q)) begin
					state_d = SEQ_IDLE;
				end
			end
			default: state_d = SEQ_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		seg_pop = 1'b0;
		issue   = 1'b0;
		unique case (state_q)
			SEQ_IDLE: seg_pop = !seg_status.empty;
			SEQ_RUN:  issue   = credit_ok;
			default: begin
				seg_pop = 1'b0;
				issue   = 1'b0;
			end
		endcase
	end

	// Control registers: state and the count of points not yet taken from
	// the output queue, which keeps that queue from overflowing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= SEQ_IDLE;
			inflight_q <= '0;
			t_q        <= '0;
		end else begin
			state_q <= state_d;
			case ({issue, out_pop})
				2'b10:   inflight_q <= inflight_q + 1'b1;
				2'b01:   inflight_q <= inflight_q - 1'b1;
				default: inflight_q <= inflight_q;
			endcase
			if (seg_pop) begin
				t_q <= '0;
			end else if (issue) begin
				t_q <= t_q + 1'b1;
			end
		end
	end

	// Segment load: coordinates, step count, n^2 and its reciprocal.
	always_ff @(posedge clk) begin
		if (seg_pop) begin
			coords_q <= head_coords;
			n_q      <= head_n;
			end_q    <= head_single ? '0 : head_n;
			d_q      <= DW'(head_n) * DW'(head_n);
			r_q      <= recip_tbl[head_n];
		end
	end

	// Pipeline valid bits.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// Pipeline payload, one lane per coordinate axis.
	logic [NW-1:0]    u_s1, t_s1;
	logic             last_s1, last_s2, last_s3, last_s4, last_s5, last_s6;
	logic [CDW-1:0]   coords_s1, coords_s2;
	logic [DW-1:0]    d_s1, d_s2, d_s3, d_s4, d_s5, d_s6;
	logic [S-1:0]     r_s1, r_s2, r_s3, r_s4;
	logic [DW-1:0]    w0_s2, w1_s2, w2_s2;
	logic [S-1:0]     pa_s3 [2];
	logic [S-1:0]     pb_s3 [2];
	logic [S-1:0]     pc_s3 [2];
	logic [S-1:0]     num_s4 [2];
	logic [S-1:0]     num_s5 [2];
	logic [S-1:0]     num_s6 [2];
	logic [2*S-1:0]   prod_s5 [2];
	logic [C-1:0]     q0_s6 [2];
	logic [S-1:0]     qd_s6 [2];
	logic [S-1:0]     rem [2];
	logic [C-1:0]     quot [2];

	always_ff @(posedge clk) begin
		// Stage 1: parameter pair (n - t, t) for the point being issued.
		u_s1      <= n_q - t_q;
		t_s1      <= t_q;
		last_s1   <= (t_q == end_q);
		coords_s1 <= coords_q;
		d_s1      <= d_q;
		r_s1      <= r_q;

		// Stage 2: Bernstein weights (n-t)^2, 2(n-t)t and t^2.
		w0_s2     <= DW'(u_s1) * DW'(u_s1);
		w1_s2     <= (DW'(u_s1) * DW'(t_s1)) << 1;
		w2_s2     <= DW'(t_s1) * DW'(t_s1);
		last_s2   <= last_s1;
		coords_s2 <= coords_s1;
		d_s2      <= d_s1;
		r_s2      <= r_s1;

		// Stage 3: weight times point for start, control and end.
		for (int l = 0; l < 2; l++) begin
			pa_s3[l] <= S'(w0_s2) * S'(coords_s2[l*C +: C]);
			pb_s3[l] <= S'(w1_s2) * S'(coords_s2[(2+l)*C +: C]);
			pc_s3[l] <= S'(w2_s2) * S'(coords_s2[(4+l)*C +: C]);
		end
		last_s3 <= last_s2;
		d_s3    <= d_s2;
		r_s3    <= r_s2;

		// Stage 4: numerator with the rounding offset n^2 / 2.
		for (int l = 0; l < 2; l++) begin
			num_s4[l] <= pa_s3[l] + pb_s3[l] + pc_s3[l] + S'(d_s3 >> 1);
		end
		last_s4 <= last_s3;
		d_s4    <= d_s3;
		r_s4    <= r_s3;

		// Stage 5: scale by the reciprocal of n^2.
		for (int l = 0; l < 2; l++) begin
			prod_s5[l] <= (2*S)'(num_s4[l]) * (2*S)'(r_s4);
			num_s5[l]  <= num_s4[l];
		end
		last_s5 <= last_s4;
		d_s5    <= d_s4;

		// Stage 6: quotient estimate and its product with n^2.
		for (int l = 0; l < 2; l++) begin
			q0_s6[l]  <= prod_s5[l][S +: C];
			qd_s6[l]  <= S'(prod_s5[l][S +: C]) * S'(d_s5);
			num_s6[l] <= num_s5[l];
		end
		last_s6 <= last_s5;
		d_s6    <= d_s5;
	end

	// Correction: the estimate is low by one when the remainder reaches n^2.
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			rem[l]  = num_s6[l] - qd_s6[l];
			quot[l] = q0_s6[l] + C'(rem[l] >= S'(d_s6));
		end
	end

	assign pt_push = v_s6;
	assign pt_data = {last_s6, quot[1], quot[0]};

endmodule

// ===== rtl/core/quadratic_bezier_point_generator.sv =====
// Top level of the quadratic curve point generator.
//
// Input stream (s_axis_*): one transaction per curve segment carrying the start,
// control and end points. Output stream (m_axis_*): one transaction per point,
// for t = 0 .. n with n the step count; tlast marks the point at t = n.
// The step count is written through cfg_valid/cfg_ready/cfg_data; the user must
// write it only while the block is idle, which the block does not enforce.
// A count of zero yields the start point alone, with tlast. A count above
// MAX_STEPS is treated as MAX_STEPS. On an idle block, the first point of a
// segment passes through the sequencer load, the six pipeline stages and the
// output queue before it is offered. The step sequencer loads each segment in
// its idle state, then issues one point per cycle while the output queue has
// room; a single-point segment issues its first point only. Up to two segments
// wait in the input queue, so the next one is taken while points are still
// being produced. When the receiver stalls, up to sixteen points collect in the
// output queue; the sequencer then holds until space frees up, and nothing is
// dropped. Reset clears the queues, the pipeline and the sequencer and sets the
// step count to twenty.
module quadratic_bezier_point_generator
	import bez_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int MAX_STEPS  = MAX_STEPS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	// Step count register write.
	input  logic                                      cfg_valid,
	output logic                                      cfg_ready,
	input  logic [STEPS_W-1:0]                        cfg_data,
	// Segment input.
	input  logic                                      s_axis_tvalid,
	output logic                                      s_axis_tready,
	// start_x, start_y, ctrl_x, ctrl_y, end_x, end_y, zero padding
	input  logic [((6*COORD_BITS+7)/8)*8-1:0]         s_axis_tdata,
	// Point output.
	output logic                                      m_axis_tvalid,
	input  logic                                      m_axis_tready,
	// point_x, point_y, zero padding
	output logic [((2*COORD_BITS+7)/8)*8-1:0]         m_axis_tdata,
	// last_point
	output logic                                      m_axis_tlast
);

	localparam int IN_TDW  = ((6 * COORD_BITS + 7) / 8) * 8;
	localparam int OUT_TDW = ((2 * COORD_BITS + 7) / 8) * 8;
	localparam int NW      = $clog2(MAX_STEPS + 1);
	localparam int SEG_W   = 6 * COORD_BITS + NW + 1;
	localparam int PT_W    = 2 * COORD_BITS + 1;

	queue_status_t    seg_status;
	logic             seg_push;
	logic [SEG_W-1:0] seg_wdata;
	logic             seg_pop;
	logic [SEG_W-1:0] seg_head;

	queue_status_t    out_status;
	logic             out_pop;
	logic             pt_push;
	logic [PT_W-1:0]  pt_data;
	logic [PT_W-1:0]  out_head;

	// Register port and segment intake.
	bez_front #(
		.COORD_BITS (COORD_BITS),
		.MAX_STEPS  (MAX_STEPS),
		.IN_TDW     (IN_TDW),
		.NW         (NW),
		.SEG_W      (SEG_W)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.seg_status    (seg_status),
		.seg_push      (seg_push),
		.seg_data      (seg_wdata)
	);

	// Segments waiting for the sequencer.
	bez_queue #(
		.WIDTH (SEG_W),
		.DEPTH (SEG_DEPTH)
	) u_seg_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (seg_push),
		.push_data (seg_wdata),
		.pop       (seg_pop),
		.head_data (seg_head),
		.status    (seg_status)
	);

	// Step sequencer and evaluation pipeline.
	bez_back #(
		.COORD_BITS (COORD_BITS),
		.MAX_STEPS  (MAX_STEPS),
		.NW         (NW),
		.SEG_W      (SEG_W),
		.PT_W       (PT_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.seg_status (seg_status),
		.seg_data   (seg_head),
		.seg_pop    (seg_pop),
		.out_pop    (out_pop),
		.pt_push    (pt_push),
		.pt_data    (pt_data)
	);

	// Finished points waiting for the receiver.
	bez_queue #(
		.WIDTH (PT_W),
		.DEPTH (OUT_DEPTH)
	) u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (pt_push),
		.push_data (pt_data),
		.pop       (out_pop),
		.head_data (out_head),
		.status    (out_status)
	);

	assign m_axis_tvalid = !out_status.empty;
	assign out_pop       = m_axis_tvalid && m_axis_tready;
	assign m_axis_tdata  = OUT_TDW'(out_head[2*COORD_BITS-1:0]);
	assign m_axis_tlast  = out_head[2*COORD_BITS];

endmodule

// ===== rtl/core/bez_checker.sv =====
// Port-level checker for the quadratic curve point generator, bound to the top level.
module bez_checker
	import bez_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              cfg_valid,
	input logic                              cfg_ready,
	input logic [STEPS_W-1:0]                cfg_data,
	input logic                              s_axis_tvalid,
	input logic                              s_axis_tready,
	input logic [((6*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	input logic [((2*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
	input logic                              m_axis_tlast
);

	// Segments accepted whose last point has not yet been taken.
	logic [7:0] pending_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			case ({s_axis_tvalid && s_axis_tready,
			       m_axis_tvalid && m_axis_tready && m_axis_tlast})
				2'b10:   pending_q <= pending_q + 1'b1;
				2'b01:   pending_q <= pending_q - 1'b1;
				default: pending_q <= pending_q;
			endcase
		end
	end

	// A point offered but not taken stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output transaction withdrawn while stalled");

	// A stalled point keeps its coordinates and last flag.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output transaction changed while stalled");

	// Every point belongs to a segment that is still open.
	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> pending_q != '0)
		else $error("point offered with no open segment");

	// Once reset has been sampled and is still asserted, the output side is empty.
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n && $past(!arst_n) |-> !m_axis_tvalid)
		else $error("output valid during reset");

endmodule

bind quadratic_bezier_point_generator bez_checker #(
	.COORD_BITS (COORD_BITS)
) u_bez_checker (.*);

// ===== verif/quadratic_bezier_point_generator_tb.sv =====
// Self-checking testbench for the quadratic curve point generator, with its own point predictor.
module quadratic_bezier_point_generator_tb;
	import bez_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = COORD_BITS_DEF;
	localparam int SEG_W = ((6*CW+7)/8)*8;
	localparam int PT_W = ((2*CW+7)/8)*8;
	localparam int COORD_MAX = (1 << CW) - 1;
	localparam int SETTLE_CYCLES = 30;
	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_PHASES = 10;
	localparam int ITEMS_PER_PHASE = 15;

	// One curve segment as carried by the input stream.
	typedef struct packed {
		logic [CW-1:0] end_y;
		logic [CW-1:0] end_x;
		logic [CW-1:0] ctrl_y;
		logic [CW-1:0] ctrl_x;
		logic [CW-1:0] start_y;
		logic [CW-1:0] start_x;
	} segment_t;

	// One curve point as carried by the output stream.
	typedef struct packed {
		logic [CW-1:0] x;
		logic [CW-1:0] y;
		logic last;
	} point_t;

	// Predicts the points of each accepted segment and checks the output against them.
	class point_scoreboard;
		point_t pending_points[$];
		logic [STEPS_W-1:0] steps;
		int errors;
		int segments;
		int points;

		function new();
			steps = STEPS_RESET;
			errors = 0;
			segments = 0;
			points = 0;
		endfunction

		// Rounded coordinate at step t of n, from the weighted sum of the three points.
		function logic [CW-1:0] bezier_coord(logic [CW-1:0] a, logic [CW-1:0] b,
			logic [CW-1:0] c, int unsigned t, int unsigned n);
			int unsigned u;
			int unsigned den;
			int unsigned num;
			u = n - t;
			den = n * n;
			num = u * u * a + 2 * u * t * b + t * t * c + (den >> 1);
			return CW'(num / den);
		endfunction

		// Called on every accepted segment transaction.
		function void add_segment(segment_t s);
			int unsigned n;
			point_t p;
			n = 32'(steps);
			if (n > MAX_STEPS_DEF) begin
				n = MAX_STEPS_DEF;
			end
			segments++;
			if (n == 0) begin
				// A zero step count gives the start point alone, marked last.
				p.x = s.start_x;
				p.y = s.start_y;
				p.last = 1'b1;
				pending_points.push_back(p);
				return;
			end
			for (int unsigned t = 0; t <= n; t++) begin
				p.x = bezier_coord(s.start_x, s.ctrl_x, s.end_x, t, n);
				p.y = bezier_coord(s.start_y, s.ctrl_y, s.end_y, t, n);
				p.last = (t == n);
				pending_points.push_back(p);
			end
		endfunction

		// Called on every accepted point transaction.
		function void check_point(point_t got);
			point_t want;
			if (pending_points.size() == 0) begin
				$error("unexpected point: x %0d, y %0d, last %0d", got.x, got.y, got.last);
				errors++;
				return;
			end
			want = pending_points.pop_front();
			points++;
			if (got.x !== want.x) begin
				$error("point_x mismatch: expected %0d, actual %0d", want.x, got.x);
				errors++;
			end
			if (got.y !== want.y) begin
				$error("point_y mismatch: expected %0d, actual %0d", want.y, got.y);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last_point mismatch: expected %0d, actual %0d", want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [STEPS_W-1:0] cfg_data;
	logic s_axis_tvalid;
	logic s_axis_tready;
	// start_x, start_y, ctrl_x, ctrl_y, end_x, end_y, zero padding
	logic [SEG_W-1:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	// point_x, point_y, zero padding
	logic [PT_W-1:0] m_axis_tdata;
	logic m_axis_tlast;

	point_scoreboard sb = new();
	int burst_left = 0;
	int settings_written = 0;

	quadratic_bezier_point_generator uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Output monitor: check every point transaction.
	always @(posedge clk) begin
		point_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.x = m_axis_tdata[CW-1:0];
			got.y = m_axis_tdata[2*CW-1:CW];
			got.last = m_axis_tlast;
			sb.check_point(got);
		end
	end

	// Receiver: switches between stall patterns after each span of random length.
	initial begin
		int mode;
		int span;
		m_axis_tready = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(8, 80);
			for (int i = 0; i < span; i++) begin
				@(negedge clk);
				case (mode)
					0: begin
						m_axis_tready = 1'b1;
					end
					1: begin
						m_axis_tready = 1'($urandom_range(0, 1));
					end
					2: begin
						m_axis_tready = ($urandom_range(0, 3) == 0);
					end
					default: begin
						// Long stall at the start of the span, then open if the span runs long enough.
						m_axis_tready = (i >= 24);
					end
				endcase
			end
		end
	end

	// Watchdog: ends the run when nothing is accepted for too long.
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
			if (quiet >= STALL_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
				$display("tb: failure");
				$finish;
			end
		end
	end

	function automatic segment_t make_segment(int sx, int sy, int cx, int cy, int ex, int ey);
		segment_t s;
		s.start_x = CW'(sx);
		s.start_y = CW'(sy);
		s.ctrl_x = CW'(cx);
		s.ctrl_y = CW'(cy);
		s.end_x = CW'(ex);
		s.end_y = CW'(ey);
		return s;
	endfunction

	// Random coordinates with extra weight on the range ends.
	function automatic logic [CW-1:0] random_coord();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			return '0;
		end
		if (pick == 1) begin
			return CW'(COORD_MAX);
		end
		return CW'($urandom_range(0, COORD_MAX));
	endfunction

	// Sends one segment; starts and ends at a falling edge. Idles between bursts.
	task automatic send_segment(segment_t s);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 8);
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? 30 : $urandom_range(1, 10);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = s;
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
		sb.add_segment(s);
		burst_left--;
		@(negedge clk);
	endtask

	// Waits until every predicted point has arrived and the pipeline is empty.
	task automatic drain();
		s_axis_tvalid = 1'b0;
		while (sb.pending_points.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	// Writes the step count once the block is idle.
	task automatic write_steps(int value);
		drain();
		cfg_valid = 1'b1;
		cfg_data = STEPS_W'(value);
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		sb.steps = STEPS_W'(value);
		settings_written++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Stimulus: reset, directed segments, then random phases.
	initial begin
		int phase_steps[RANDOM_PHASES];
		phase_steps = '{1, 0, 63, 3, 7, 2, 31, 5, 62, 20};
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset step count: range ends and opposed control points.
		send_segment(make_segment(0, 0, 0, 0, 0, 0));
		send_segment(make_segment(255, 255, 255, 255, 255, 255));
		send_segment(make_segment(0, 255, 255, 0, 0, 255));
		send_segment(make_segment(255, 0, 0, 255, 255, 0));
		send_segment(make_segment(0, 0, 128, 128, 255, 255));

		// Zero step count yields the start point alone.
		write_steps(0);
		send_segment(make_segment(255, 255, 0, 0, 0, 0));
		send_segment(make_segment(170, 85, 85, 170, 170, 85));
		send_segment(make_segment(0, 0, 255, 255, 255, 255));

		// One step: start and end points only.
		write_steps(1);
		send_segment(make_segment(0, 255, 255, 0, 255, 0));
		send_segment(make_segment(85, 170, 170, 85, 85, 170));
		send_segment(make_segment(1, 254, 127, 128, 254, 1));

		// Largest step count, with full-scale points for the widest sums.
		write_steps(63);
		send_segment(make_segment(255, 255, 255, 255, 255, 255));
		send_segment(make_segment(0, 0, 255, 255, 0, 0));
		send_segment(make_segment(255, 0, 0, 255, 255, 0));
		send_segment(make_segment(0, 255, 128, 127, 255, 0));

		// Two steps: the first segment's middle point lands on exact halves.
		write_steps(2);
		send_segment(make_segment(0, 1, 1, 0, 0, 1));
		send_segment(make_segment(1, 0, 0, 1, 2, 3));
		send_segment(make_segment(255, 254, 0, 1, 1, 0));

		// Random segments over a spread of step counts.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			write_steps((ph == RANDOM_PHASES - 1) ? $urandom_range(0, 63) : phase_steps[ph]);
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				send_segment(make_segment(random_coord(), random_coord(), random_coord(),
					random_coord(), random_coord(), random_coord()));
			end
		end

		drain();
		$display("summary: %0d segments sent, %0d points checked", sb.segments, sb.points);
		$display("summary: %0d step-count writes, from zero to the largest count",
			settings_written);
		if (sb.errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/bez_pkg.sv
rtl/core/bez_queue.sv
rtl/core/bez_front.sv
rtl/core/bez_back.sv
rtl/core/quadratic_bezier_point_generator.sv
rtl/core/bez_checker.sv
verif/quadratic_bezier_point_generator_tb.sv
